>>> hw/rtl/mrg5_pkg.sv
package mrg5_pkg;

  localparam int unsigned WORD_W    = 31;
  localparam int unsigned NUM_WORDS = 5;
  localparam int unsigned NUM_JUMP  = 9;
  localparam int unsigned NUM_COEF  = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SLOT_W    = 5;

  localparam logic [WORD_W-1:0] MRG_M = 31'h7fffffff;
  localparam logic [WORD_W-1:0] MRG_X = 31'd107374182;
  localparam logic [WORD_W-1:0] MRG_Y = 31'd104480;

  localparam logic [1:0] OP_STEP   = 2'd0;
  localparam logic [1:0] OP_JUMP   = 2'd1;
  localparam logic [1:0] OP_RELOAD = 2'd2;

  localparam logic [SLOT_W-1:0] STEP_LAST = 5'd1;
  localparam logic [SLOT_W-1:0] JUMP_LAST = 5'd28;

  // multiplicand select: jump entries s t u v w a b c d, scaled ones, constants
  typedef enum logic [3:0] {
    P_S, P_T, P_U, P_V, P_W, P_A, P_B, P_C, P_D,
    P_SY, P_AY, P_BY, P_CY, P_X, P_Y
  } psel_t;

  typedef enum logic [2:0] {
    Q_Z1, Q_Z2, Q_Z3, Q_Z4, Q_Z5, Q_Y
  } qsel_t;

  typedef enum logic [3:0] {
    D_SY, D_AY, D_BY, D_CY, D_O1, D_O2, D_O3, D_O4, D_O5
  } dest_t;

  typedef struct packed {
    psel_t p;
    qsel_t q;
    logic  first;
    logic  last;
    dest_t dest;
  } uop_t;

  function automatic logic [WORD_W-1:0] red31(input logic [WORD_W-1:0] x);
    red31 = (x == MRG_M) ? '0 : x;
  endfunction

  // sum of three values below 2^31, reduced modulo 2^31-1
  function automatic logic [WORD_W-1:0] red33(input logic [32:0] s);
    logic [31:0] f;
    f = {1'b0, s[30:0]} + {30'd0, s[32:31]};
    if (f >= {1'b0, MRG_M}) begin
      f = f - {1'b0, MRG_M};
    end
    red33 = f[WORD_W-1:0];
  endfunction

  function automatic uop_t step_uop(input logic [SLOT_W-1:0] slot);
    uop_t u;
    case (slot)
      5'd0:    u = '{P_X, Q_Z1, 1'b1, 1'b0, D_O1};
      default: u = '{P_Y, Q_Z5, 1'b0, 1'b1, D_O1};
    endcase
    step_uop = u;
  endfunction

  function automatic uop_t jump_uop(input logic [SLOT_W-1:0] slot);
    uop_t u;
    case (slot)
      5'd0:    u = '{P_S,  Q_Y,  1'b1, 1'b1, D_SY};
      5'd1:    u = '{P_A,  Q_Y,  1'b1, 1'b1, D_AY};
      5'd2:    u = '{P_B,  Q_Y,  1'b1, 1'b1, D_BY};
      5'd3:    u = '{P_C,  Q_Y,  1'b1, 1'b1, D_CY};
      5'd4:    u = '{P_S,  Q_Z1, 1'b1, 1'b0, D_O5};
      5'd5:    u = '{P_T,  Q_Z2, 1'b0, 1'b0, D_O5};
      5'd6:    u = '{P_U,  Q_Z3, 1'b0, 1'b0, D_O5};
      5'd7:    u = '{P_V,  Q_Z4, 1'b0, 1'b0, D_O5};
      5'd8:    u = '{P_W,  Q_Z5, 1'b0, 1'b1, D_O5};
      5'd9:    u = '{P_A,  Q_Z1, 1'b1, 1'b0, D_O4};
      5'd10:   u = '{P_U,  Q_Z2, 1'b0, 1'b0, D_O4};
      5'd11:   u = '{P_V,  Q_Z3, 1'b0, 1'b0, D_O4};
      5'd12:   u = '{P_W,  Q_Z4, 1'b0, 1'b0, D_O4};
      5'd13:   u = '{P_SY, Q_Z5, 1'b0, 1'b1, D_O4};
      5'd14:   u = '{P_B,  Q_Z1, 1'b1, 1'b0, D_O3};
      5'd15:   u = '{P_V,  Q_Z2, 1'b0, 1'b0, D_O3};
      5'd16:   u = '{P_W,  Q_Z3, 1'b0, 1'b0, D_O3};
      5'd17:   u = '{P_SY, Q_Z4, 1'b0, 1'b0, D_O3};
      5'd18:   u = '{P_AY, Q_Z5, 1'b0, 1'b1, D_O3};
      5'd19:   u = '{P_C,  Q_Z1, 1'b1, 1'b0, D_O2};
      5'd20:   u = '{P_W,  Q_Z2, 1'b0, 1'b0, D_O2};
      5'd21:   u = '{P_SY, Q_Z3, 1'b0, 1'b0, D_O2};
      5'd22:   u = '{P_AY, Q_Z4, 1'b0, 1'b0, D_O2};
      5'd23:   u = '{P_BY, Q_Z5, 1'b0, 1'b1, D_O2};
      5'd24:   u = '{P_D,  Q_Z1, 1'b1, 1'b0, D_O1};
      5'd25:   u = '{P_SY, Q_Z2, 1'b0, 1'b0, D_O1};
      5'd26:   u = '{P_AY, Q_Z3, 1'b0, 1'b0, D_O1};
      5'd27:   u = '{P_BY, Q_Z4, 1'b0, 1'b0, D_O1};
      default: u = '{P_CY, Q_Z5, 1'b0, 1'b1, D_O1};
    endcase
    jump_uop = u;
  endfunction

endpackage

>>> hw/rtl/mrg5_random_generator_with_jump.sv
// five-word recursive generator modulo 2^31-1 on one shared multiply-accumulate unit
// path from accept to out_tvalid: step and jump pass S_RUN, S_DRAIN, S_FIN; reload and unused op go to S_FIN
// one item at a time (in_tready only in S_IDLE); the single 31x31 multiply-accumulate unit
// takes one product per cycle (2 for a step, 29 for a jump) in S_RUN, then drains in S_DRAIN
// reset (rst_n low, synchronous): seeds become 1,0,0,0,0, state words load them, no output
module mrg5_random_generator_with_jump (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // jump_s, jump_t, jump_u, jump_v, jump_w, jump_a, jump_b, jump_c, jump_d, pad
  input  logic [279:0]                      in_tdata,
  // op
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // random_value, pad
  output logic [31:0]                       out_tdata,
  input  logic                              cfg_we,
  input  logic [mrg5_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [mrg5_pkg::WORD_W-1:0]       cfg_wdata
);
  import mrg5_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE, S_RUN, S_DRAIN, S_FIN
  } state_t;

  state_t            state_r;
  logic [SLOT_W-1:0] slot_r;
  logic              is_jump_r;
  logic              tag_vld_r;
  logic              tag_first_r;
  logic              tag_last_r;
  dest_t             tag_dest_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_data_r;

  logic [WORD_W-1:0] seed_r [NUM_WORDS];
  logic [WORD_W-1:0] z_r    [NUM_WORDS];
  logic [WORD_W-1:0] o_r    [NUM_WORDS];
  logic [WORD_W-1:0] j_r    [NUM_JUMP];
  logic [WORD_W-1:0] coef_r [NUM_COEF];
  logic [WORD_W-1:0] acc_r;
  logic [61:0]       prod_r;

  uop_t              uop;
  logic [WORD_W-1:0] p_val;
  logic [WORD_W-1:0] q_val;
  logic [61:0]       prod_nxt;
  logic [32:0]       sum;
  logic [WORD_W-1:0] acc_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

  always_comb begin
    uop = is_jump_r ? jump_uop(slot_r) : step_uop(slot_r);
    case (uop.p)
      P_S:     p_val = j_r[0];
      P_T:     p_val = j_r[1];
      P_U:     p_val = j_r[2];
      P_V:     p_val = j_r[3];
      P_W:     p_val = j_r[4];
      P_A:     p_val = j_r[5];
      P_B:     p_val = j_r[6];
      P_C:     p_val = j_r[7];
      P_D:     p_val = j_r[8];
      P_SY:    p_val = coef_r[0];
      P_AY:    p_val = coef_r[1];
      P_BY:    p_val = coef_r[2];
      P_CY:    p_val = coef_r[3];
      P_X:     p_val = MRG_X;
      default: p_val = MRG_Y;
    endcase
    case (uop.q)
      Q_Z1:    q_val = z_r[0];
      Q_Z2:    q_val = z_r[1];
      Q_Z3:    q_val = z_r[2];
      Q_Z4:    q_val = z_r[3];
      Q_Z5:    q_val = z_r[4];
      default: q_val = MRG_Y;
    endcase
    prod_nxt = {31'd0, p_val} * {31'd0, q_val};
    sum = {2'b00, prod_r[30:0]} + {2'b00, prod_r[61:31]} +
          (tag_first_r ? 33'd0 : {2'b00, acc_r});
    acc_nxt = red33(sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      is_jump_r   <= 1'b0;
      tag_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      seed_r[0]   <= 31'd1;
      z_r[0]      <= 31'd1;
      for (int i = 1; i < NUM_WORDS; i++) begin
        seed_r[i] <= '0;
        z_r[i]    <= '0;
      end
    end else begin
      if (cfg_we && (cfg_addr < CFG_IDX_W'(NUM_WORDS))) begin
        seed_r[cfg_addr] <= cfg_wdata;
      end
      if (out_valid_r && out_tready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end

      // multiply stage feeds the accumulate stage in the following cycle, through prod_r and the tags
      tag_vld_r   <= (state_r == S_RUN);
      tag_first_r <= uop.first;
      tag_last_r  <= uop.last;
      tag_dest_r  <= uop.dest;
      prod_r      <= prod_nxt;
      if (tag_vld_r) begin
        acc_r <= acc_nxt;
        if (tag_last_r) begin
          case (tag_dest_r)
            D_SY:    coef_r[0] <= acc_nxt;
            D_AY:    coef_r[1] <= acc_nxt;
            D_BY:    coef_r[2] <= acc_nxt;
            D_CY:    coef_r[3] <= acc_nxt;
            D_O1:    o_r[0]    <= acc_nxt;
            D_O2:    o_r[1]    <= acc_nxt;
            D_O3:    o_r[2]    <= acc_nxt;
            D_O4:    o_r[3]    <= acc_nxt;
            default: o_r[4]    <= acc_nxt;
          endcase
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            for (int i = 0; i < NUM_JUMP; i++) begin
              j_r[i] <= red31(in_tdata[i*WORD_W +: WORD_W]);
            end
            slot_r    <= '0;
            is_jump_r <= (in_tuser == OP_JUMP);
            unique case (in_tuser)
              OP_STEP: begin
                for (int i = 1; i < NUM_WORDS; i++) begin
                  o_r[i] <= z_r[i-1];
                end
                state_r <= S_RUN;
              end
              OP_JUMP: begin
                state_r <= S_RUN;
              end
              OP_RELOAD: begin
                for (int i = 0; i < NUM_WORDS; i++) begin
                  o_r[i] <= red31(seed_r[i]);
                end
                state_r <= S_FIN;
              end
              default: begin
                for (int i = 0; i < NUM_WORDS; i++) begin
                  o_r[i] <= z_r[i];
                end
                state_r <= S_FIN;
              end
            endcase
          end
        end
        S_RUN: begin
          slot_r <= slot_r + 5'd1;
          if (slot_r == (is_jump_r ? JUMP_LAST : STEP_LAST)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_FIN;
        end
        default: begin
          if (!out_valid_r || out_tready) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
              z_r[i] <= o_r[i];
            end
            out_valid_r <= 1'b1;
            out_data_r  <= o_r[0];
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

>>> tb/mrg5_random_generator_with_jump_tb.sv
module mrg5_random_generator_with_jump_tb;
  import mrg5_pkg::*;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [63:0] wide_t;
  typedef logic [NUM_JUMP-1:0][WORD_W-1:0] jump_row_t;
  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] seed_set_t;
  typedef enum int {J_S, J_T, J_U, J_V, J_W, J_A, J_B, J_C, J_D} jidx_t;

  typedef struct packed {
    logic [1:0] op;
    jump_row_t  jw;
    logic       lit_ok;
    word_t      lit;
  } dir_row_t;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam wide_t MOD = 64'd2147483647;
  localparam word_t M_VAL = MRG_M;
  localparam word_t MAX_OK = MRG_M - 31'd1;

  localparam int DIR_ROWS = 22;
  localparam int NUM_PHASES = 6;
  localparam int RAND_PER_PHASE = 275;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 400000;

  localparam jump_row_t JR_ZERO = '0;
  localparam jump_row_t JR_ONES = '1;
  localparam jump_row_t JR_ALL_M = {NUM_JUMP{M_VAL}};
  localparam jump_row_t JR_ALL_MAX = {NUM_JUMP{MAX_OK}};
  localparam jump_row_t JR_ALT = {{4{31'h2aaaaaaa, 31'h55555555}}, 31'h2aaaaaaa};
  // d c b a w v u t s
  localparam jump_row_t JR_IDENTITY = {31'd1, 31'd0, 31'd0, 31'd0, 31'd1,
                                       31'd0, 31'd0, 31'd0, 31'd0};

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [279:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;
  logic         cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [WORD_W-1:0]    cfg_wdata;

  word_t    gen_z [NUM_WORDS];
  word_t    seed_r [NUM_WORDS];
  word_t    pending_values [$];
  dir_row_t dir_tab [DIR_ROWS];

  int snd_idle;
  int rcv_idle;
  int err_cnt;
  int results_seen;
  int cycle_cnt;
  int n_step, n_jump, n_jump_ok, n_reload, n_unused;

  mrg5_random_generator_with_jump u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic wide_t mod_mac(input wide_t acc, input wide_t p, input wide_t q);
    return (acc + (p * q) % MOD) % MOD;
  endfunction

  // advances the generator copy by one item and returns the new z1
  function automatic word_t apply_item(input logic [1:0] op, input jump_row_t jw);
    wide_t z [NUM_WORDS];
    wide_t e [NUM_JUMP];
    wide_t h, o1, o2, o3, o4, o5, nw;
    int i;
    for (i = 0; i < NUM_WORDS; i++) z[i] = gen_z[i];
    case (op)
      OP_STEP: begin
        nw = mod_mac(mod_mac(0, MRG_X, z[0]), MRG_Y, z[4]);
        for (i = NUM_WORDS - 1; i > 0; i--) gen_z[i] = gen_z[i-1];
        gen_z[0] = word_t'(nw);
      end
      OP_JUMP: begin
        for (i = 0; i < NUM_JUMP; i++) e[i] = jw[i] % MOD;
        h  = mod_mac(mod_mac(mod_mac(mod_mac(0, e[J_S], z[1]), e[J_A], z[2]),
                             e[J_B], z[3]), e[J_C], z[4]);
        o1 = mod_mac(mod_mac(0, e[J_D], z[0]), MRG_Y, h);
        h  = mod_mac(mod_mac(mod_mac(0, e[J_S], z[2]), e[J_A], z[3]), e[J_B], z[4]);
        o2 = mod_mac(mod_mac(mod_mac(0, e[J_C], z[0]), e[J_W], z[1]), MRG_Y, h);
        h  = mod_mac(mod_mac(0, e[J_S], z[3]), e[J_A], z[4]);
        o3 = mod_mac(mod_mac(mod_mac(mod_mac(0, e[J_B], z[0]), e[J_V], z[1]),
                             e[J_W], z[2]), MRG_Y, h);
        h  = mod_mac(0, e[J_S], z[4]);
        o4 = mod_mac(mod_mac(mod_mac(mod_mac(mod_mac(0, e[J_A], z[0]), e[J_U], z[1]),
                                     e[J_V], z[2]), e[J_W], z[3]), MRG_Y, h);
        o5 = mod_mac(mod_mac(mod_mac(mod_mac(mod_mac(0, e[J_S], z[0]), e[J_T], z[1]),
                                     e[J_U], z[2]), e[J_V], z[3]), e[J_W], z[4]);
        gen_z[0] = word_t'(o1);
        gen_z[1] = word_t'(o2);
        gen_z[2] = word_t'(o3);
        gen_z[3] = word_t'(o4);
        gen_z[4] = word_t'(o5);
      end
      OP_RELOAD: begin
        for (i = 0; i < NUM_WORDS; i++) gen_z[i] = word_t'(seed_r[i] % MOD);
      end
      default: ;
    endcase
    return gen_z[0];
  endfunction

  // mostly uniform, with zero and the two top codes showing up often
  function automatic word_t rand_word();
    case ($urandom_range(31))
      0:       return '0;
      1:       return M_VAL;
      2:       return MAX_OK;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic jump_row_t random_row();
    jump_row_t jw;
    int i;
    for (i = 0; i < NUM_JUMP; i++) jw[i] = rand_word();
    return jw;
  endfunction

  // a, b, c, d derived from the bottom row as a real matrix power has them
  function automatic jump_row_t matched_row();
    jump_row_t jw;
    jw = random_row();
    jw[J_A] = word_t'(mod_mac(jw[J_T] % MOD, MRG_X, jw[J_S] % MOD));
    jw[J_B] = word_t'(mod_mac(jw[J_U] % MOD, MRG_X, jw[J_A]));
    jw[J_C] = word_t'(mod_mac(jw[J_V] % MOD, MRG_X, jw[J_B]));
    jw[J_D] = word_t'(mod_mac(jw[J_W] % MOD, MRG_X, jw[J_C]));
    return jw;
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("mismatch at %0t: %s, got %0d, expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // writes all seed registers, then the indexes past them, which must be ignored
  task automatic program_seeds(input seed_set_t vals);
    int i;
    for (i = 0; i < 2**CFG_IDX_W; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_IDX_W'(i);
      cfg_wdata <= (i < NUM_WORDS) ? vals[i] : word_t'($urandom);
      if (i < NUM_WORDS) seed_r[i] = vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_values.size() != 0) @(negedge clk);
  endtask

  task automatic offer_item(input logic [1:0] op, input jump_row_t jw,
                            input logic lit_ok, input word_t lit);
    word_t pred;
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, jw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = apply_item(op, jw);
    pending_values.push_back(lit_ok ? lit : pred);
    case (op)
      OP_STEP:   n_step++;
      OP_JUMP:   n_jump++;
      OP_RELOAD: n_reload++;
      default:   n_unused++;
    endcase
    @(negedge clk);
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (results_seen == HOLD_AT && !hold_done) begin
        hold_left  = HOLD_CYCLES - 1;
        hold_done  = 1'b1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle);
      end
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_values.size() == 0) begin
          report_mismatch("result transfer with nothing pending", out_tdata[WORD_W-1:0], '0);
        end else begin
          word_t want;
          want = pending_values.pop_front();
          if (out_tdata[WORD_W-1:0] !== want) begin
            report_mismatch("random_value", out_tdata[WORD_W-1:0], want);
          end
        end
        results_seen++;
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("run limit of %0d cycles reached", LIMIT_CYCLES);
    $display("FAIL mrg5_random_generator_with_jump");
    $finish;
  end

  initial begin
    int ph, k, r;
    seed_set_t seeds;
    jump_row_t jw;
    logic [1:0] op;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    err_cnt = 0;
    results_seen = 0;
    n_step = 0; n_jump = 0; n_jump_ok = 0; n_reload = 0; n_unused = 0;
    for (k = 0; k < NUM_WORDS; k++) begin
      seed_r[k] = (k == 0) ? 31'd1 : 31'd0;
      gen_z[k]  = seed_r[k];
    end

    dir_tab = '{
      '{OP_UNUSED, JR_ZERO,     1'b1, 31'd1},
      '{OP_RELOAD, JR_ZERO,     1'b1, 31'd1},
      '{OP_STEP,   JR_ZERO,     1'b1, MRG_X},
      '{OP_STEP,   JR_ZERO,     1'b0, 31'd0},
      '{OP_JUMP,   JR_IDENTITY, 1'b0, 31'd0},
      '{OP_STEP,   JR_ZERO,     1'b0, 31'd0},
      '{OP_STEP,   JR_ZERO,     1'b0, 31'd0},
      '{OP_STEP,   JR_ZERO,     1'b0, 31'd0},
      '{OP_JUMP,   JR_ALL_M,    1'b1, 31'd0},
      '{OP_STEP,   JR_ZERO,     1'b1, 31'd0},
      '{OP_UNUSED, JR_ALL_M,    1'b1, 31'd0},
      '{OP_RELOAD, JR_ZERO,     1'b1, 31'd1},
      '{OP_STEP,   JR_ZERO,     1'b0, 31'd0},
      '{OP_STEP,   JR_ZERO,     1'b0, 31'd0},
      '{OP_STEP,   JR_ZERO,     1'b0, 31'd0},
      '{OP_STEP,   JR_ZERO,     1'b0, 31'd0},
      '{OP_JUMP,   JR_ALL_MAX,  1'b0, 31'd0},
      '{OP_JUMP,   JR_ALT,      1'b0, 31'd0},
      '{OP_STEP,   JR_ONES,     1'b0, 31'd0},
      '{OP_JUMP,   JR_IDENTITY, 1'b0, 31'd0},
      '{OP_RELOAD, JR_ONES,     1'b1, 31'd1},
      '{OP_UNUSED, JR_ONES,     1'b1, 31'd1}
    };

    snd_idle = 14;
    rcv_idle = 74;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (k = 0; k < DIR_ROWS; k++) begin
      offer_item(dir_tab[k].op, dir_tab[k].jw, dir_tab[k].lit_ok, dir_tab[k].lit);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      if (ph < 2) begin
        snd_idle = 14;
        rcv_idle = 74;
      end else if (ph < 4) begin
        snd_idle = 74;
        rcv_idle = 14;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      for (k = 0; k < NUM_WORDS; k++) begin
        case (ph)
          1:       seeds[k] = M_VAL;
          2:       seeds[k] = MAX_OK;
          3:       seeds[k] = '0;
          4:       seeds[k] = rand_word();
          default: seeds[k] = word_t'($urandom);
        endcase
      end
      program_seeds(seeds);

      for (k = 0; k < RAND_PER_PHASE; k++) begin
        if (ph == 3 && k == RAND_PER_PHASE / 2) wait_idle();
        r  = $urandom_range(99);
        jw = random_row();
        if (r < 70) begin
          op = OP_STEP;
        end else if (r < 88) begin
          op = OP_JUMP;
          if ($urandom_range(9) < 7) begin
            jw = matched_row();
            n_jump_ok++;
          end
        end else if (r < 94) begin
          op = OP_RELOAD;
        end else begin
          op = OP_UNUSED;
        end
        offer_item(op, jw, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d steps, %0d jumps (%0d with matching derived entries), %0d reloads,",
             n_step, n_jump, n_jump_ok, n_reload);
    $display("%0d unused op codes; %0d results checked across %0d seed settings",
             n_unused, results_seen, NUM_PHASES + 1);
    if (err_cnt == 0 && pending_values.size() == 0) begin
      $display("PASS mrg5_random_generator_with_jump");
    end else begin
      $display("FAIL mrg5_random_generator_with_jump");
    end
    $finish;
  end

endmodule
